/* design/bre_pkg.sv */
// Shared widths, fixed-point constants and helper functions for the bridge reliability evaluator.
package bre_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = FRAC_BITS + 1;
  localparam int FX_W      = FRAC_BITS + 4;
  localparam int PROD_W    = 2 * FX_W;
  localparam int SUM_W     = FX_W + 1;

  typedef logic [VAL_W-1:0]         val_t;
  typedef logic signed [FX_W-1:0]   fx_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  localparam val_t  VAL_ONE  = VAL_W'(1) << FRAC_BITS;
  localparam fx_t   FX_ONE   = FX_W'(1) << FRAC_BITS;
  localparam fx_t   FX_TWO   = FX_W'(1) << (FRAC_BITS + 1);
  localparam fx_t   FX_ZERO  = '0;
  localparam prod_t RND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam sum_t  SUM_ONE  = SUM_W'(1) << FRAC_BITS;

  function automatic fx_t sat_in(val_t v);
    fx_t res;
    if (v > VAL_ONE) begin
      res = FX_ONE;
    end else begin
      res = $signed({{(FX_W-VAL_W){1'b0}}, v});
    end
    return res;
  endfunction

  function automatic val_t clamp_out(sum_t s);
    val_t res;
    if (s[SUM_W-1]) begin
      res = '0;
    end else if (s > SUM_ONE) begin
      res = VAL_ONE;
    end else begin
      res = s[VAL_W-1:0];
    end
    return res;
  endfunction

endpackage

/* design/bre_fxmul.sv */
// Signed fixed-point multiplier with rounding to nearest, halves away from zero.
module bre_fxmul
  import bre_pkg::*;
(
  input  fx_t a,
  input  fx_t b,
  output fx_t p
);

  prod_t prod;
  prod_t rnd;

  assign prod = prod_t'(a) * prod_t'(b);
  assign rnd  = prod + RND_HALF - $signed({{(PROD_W-1){1'b0}}, prod[PROD_W-1]});
  assign p    = $signed(rnd[FRAC_BITS +: FX_W]);

endmodule

/* design/bridge_reliability_eval.sv */
// Top level of the bridge network reliability evaluator: five-stage multiply pipeline.
//
//   Channel   Direction  Handshake              Payload
//   in_       input      in_valid / in_ready    in_rel_one .. in_rel_bridge, 17 bits each
//   out_      output     out_valid / out_ready  out_sys_reliability, 17 bits
//   cfg_      input      cfg_we                 cfg_wdata, identical_mode bit
//
// A request accepted at the input passes through five register stages, and a new request
// can enter every cycle while out_ready does not hold the output. The stage chain is set by
// the four dependent rounded multiplies, one per stage, followed by the output
// register holding the clamped sum.
// Reset clears the valid bits and the mode register. Each stage has its own valid bit and
// loads whenever it is empty or the stage after it moves, so bubbles close up under a stall.
module bridge_reliability_eval
  import bre_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_wdata,
  input  logic in_valid,
  output logic in_ready,
  input  val_t in_rel_one,
  input  val_t in_rel_two,
  input  val_t in_rel_three,
  input  val_t in_rel_four,
  input  val_t in_rel_bridge,
  output logic out_valid,
  input  logic out_ready,
  output val_t out_sys_reliability
);

  logic mode_r;

  logic v1_r, v2_r, v3_r, v4_r, vo_r;
  logic md1_r, md2_r, md3_r;
  logic rdy1, rdy2, rdy3, rdy4, rdyo;

  fx_t  r1_r [5];
  fx_t  a1_r [4];
  fx_t  r2a_r, r2e_r;
  fx_t  x2_r [5];
  fx_t  r3a_r, r3e_r;
  fx_t  x3_r [2];
  fx_t  y4_r, c4_r;
  val_t out_r;

  fx_t  rs [5];
  fx_t  u0;
  fx_t  m1a [4];
  fx_t  m1b [4];
  fx_t  m1p [4];
  fx_t  u2, m2aa, m2ab, m2ba, m2bb, m2ap, m2bp;
  fx_t  x2_nxt [5];
  fx_t  u3, m3a, m3b, m3p;
  fx_t  x3_nxt [2];
  fx_t  m4a, m4b, m4p;
  fx_t  c4_nxt;
  val_t out_nxt;

  assign rdyo     = !vo_r || out_ready;
  assign rdy4     = !v4_r || rdyo;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign out_valid           = vo_r;
  assign out_sys_reliability = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  always_comb begin
    rs[0] = sat_in(in_rel_one);
    rs[1] = sat_in(in_rel_two);
    rs[2] = sat_in(in_rel_three);
    rs[3] = sat_in(in_rel_four);
    rs[4] = sat_in(in_rel_bridge);
    u0    = FX_ONE - rs[0];
    if (mode_r) begin
      m1a[0] = rs[0]; m1b[0] = rs[0];
      m1a[1] = u0;    m1b[1] = u0;
      m1a[2] = FX_ZERO; m1b[2] = FX_ZERO;
      m1a[3] = FX_ZERO; m1b[3] = FX_ZERO;
    end else begin
      m1a[0] = rs[0]; m1b[0] = rs[2];
      m1a[1] = rs[1]; m1b[1] = rs[3];
      m1a[2] = rs[2]; m1b[2] = rs[3];
      m1a[3] = rs[0]; m1b[3] = rs[1];
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_mul1
    bre_fxmul u_mul (.a(m1a[g]), .b(m1b[g]), .p(m1p[g]));
  end

  always_comb begin
    u2 = FX_ONE - r1_r[0];
    if (md1_r) begin
      m2aa = FX_TWO - a1_r[0];
      m2ab = r1_r[0];
      m2ba = a1_r[1] - FX_TWO;
      m2bb = u2;
    end else begin
      m2aa = a1_r[2];
      m2ab = a1_r[3];
      m2ba = FX_ZERO;
      m2bb = FX_ZERO;
    end
  end

  bre_fxmul u_mul2a (.a(m2aa), .b(m2ab), .p(m2ap));
  bre_fxmul u_mul2b (.a(m2ba), .b(m2bb), .p(m2bp));

  always_comb begin
    if (md1_r) begin
      x2_nxt[0] = m2ap;
      x2_nxt[1] = m2bp;
      x2_nxt[2] = FX_ZERO;
      x2_nxt[3] = FX_ZERO;
      x2_nxt[4] = FX_ZERO;
    end else begin
      x2_nxt[0] = r1_r[0] + r1_r[2] - a1_r[0];
      x2_nxt[1] = r1_r[1] + r1_r[3] - a1_r[1];
      x2_nxt[2] = a1_r[2];
      x2_nxt[3] = a1_r[3];
      x2_nxt[4] = m2ap;
    end
  end

  always_comb begin
    u3 = FX_ONE - r2a_r;
    if (md2_r) begin
      m3a       = x2_r[0] + x2_r[1];
      m3b       = u3;
      x3_nxt[1] = FX_ZERO;
    end else begin
      m3a       = x2_r[0];
      m3b       = x2_r[1];
      x3_nxt[1] = x2_r[2] - x2_r[4] + x2_r[3];
    end
    x3_nxt[0] = m3p;
  end

  bre_fxmul u_mul3 (.a(m3a), .b(m3b), .p(m3p));

  always_comb begin
    if (md3_r) begin
      m4a    = x3_r[0] + FX_ONE;
      m4b    = r3a_r;
      c4_nxt = FX_ZERO;
    end else begin
      m4a    = r3e_r;
      m4b    = x3_r[0] - x3_r[1];
      c4_nxt = x3_r[1];
    end
  end

  bre_fxmul u_mul4 (.a(m4a), .b(m4b), .p(m4p));

  assign out_nxt = clamp_out(sum_t'(y4_r) + sum_t'(c4_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdyo) vo_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      md1_r <= mode_r;
      r1_r  <= rs;
      a1_r  <= m1p;
    end
    if (rdy2 && v1_r) begin
      md2_r <= md1_r;
      r2a_r <= r1_r[0];
      r2e_r <= r1_r[4];
      x2_r  <= x2_nxt;
    end
    if (rdy3 && v2_r) begin
      md3_r <= md2_r;
      r3a_r <= r2a_r;
      r3e_r <= r2e_r;
      x3_r  <= x3_nxt;
    end
    if (rdy4 && v3_r) begin
      y4_r  <= m4p;
      c4_r  <= c4_nxt;
    end
    if (rdyo && v4_r) begin
      out_r <= out_nxt;
    end
  end

endmodule

/* design/bre_chk.sv */
// Port-level checker for the bridge reliability evaluator, bound to the top level.
module bre_chk
  import bre_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input val_t out_sys_reliability
);

  logic [2:0] inflight_r;
  logic [2:0] inflight_nxt;

  always_comb begin
    inflight_nxt = inflight_r;
    if (in_valid && in_ready && !(out_valid && out_ready)) begin
      inflight_nxt = inflight_r + 3'd1;
    end else if (!(in_valid && in_ready) && out_valid && out_ready) begin
      inflight_nxt = inflight_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sys_reliability))
    else $error("Result changed or dropped while stalled.");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sys_reliability <= VAL_ONE)
    else $error("Result above one.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 3'd0)
    else $error("Result without an outstanding request.");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= 3'd5)
    else $error("More requests in flight than pipeline stages.");

endmodule

bind bridge_reliability_eval bre_chk u_bre_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_sys_reliability (out_sys_reliability)
);

/* tb/testbench.sv */
// Self-checking testbench for the bridge network reliability evaluator.
`timescale 1ns / 1ps

module testbench;
  import bre_pkg::*;

  localparam int     CYCLE_LIMIT = 200000;
  localparam longint UNIT        = longint'(1) << FRAC_BITS;
  localparam longint HALF_LSB    = longint'(1) << (FRAC_BITS - 1);
  localparam val_t   REL_MAX     = '1;
  localparam val_t   REL_HALF    = VAL_ONE >> 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  val_t in_rel_one = '0;
  val_t in_rel_two = '0;
  val_t in_rel_three = '0;
  val_t in_rel_four = '0;
  val_t in_rel_bridge = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  val_t out_sys_reliability;

  val_t pending_reliability[$];
  logic identical_shadow = 1'b0;
  bit   quiet = 1'b0;
  int   stall_left = 0;
  int   cycle_count = 0;
  int   error_count = 0;
  int   results_checked = 0;
  int   generic_items = 0;
  int   identical_items = 0;
  int   mode_writes = 0;

  bridge_reliability_eval dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rel_one          (in_rel_one),
    .in_rel_two          (in_rel_two),
    .in_rel_three        (in_rel_three),
    .in_rel_four         (in_rel_four),
    .in_rel_bridge       (in_rel_bridge),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_sys_reliability (out_sys_reliability)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Products are rounded to nearest with halves away from zero.
  function automatic longint round_mul(longint a, longint b);
    longint ma;
    longint mb;
    longint p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = (ma * mb + HALF_LSB) >>> FRAC_BITS;
    return ((a < 0) != (b < 0)) ? -p : p;
  endfunction

  function automatic longint sat_unit(val_t v);
    return (v > VAL_ONE) ? UNIT : longint'(v);
  endfunction

  function automatic val_t predict_reliability(logic identical, val_t v1, val_t v2, val_t v3,
                                               val_t v4, val_t v5);
    longint r1, r2, r3, r4, r5, u, a, b, s13, s24, val1, val2, p12, p34, res;
    r1 = sat_unit(v1);
    r2 = sat_unit(v2);
    r3 = sat_unit(v3);
    r4 = sat_unit(v4);
    r5 = sat_unit(v5);
    if (identical) begin
      u = UNIT - r1;
      a = round_mul(2 * UNIT - round_mul(r1, r1), r1);
      b = round_mul(round_mul(u, u) - 2 * UNIT, u) + a;
      b = round_mul(b, u) + UNIT;
      res = round_mul(b, r1);
    end else begin
      s13 = r1 + r3 - round_mul(r1, r3);
      s24 = r2 + r4 - round_mul(r2, r4);
      val1 = round_mul(s13, s24);
      p34 = round_mul(r3, r4);
      p12 = round_mul(r1, r2);
      val2 = (p34 - round_mul(p34, p12)) + p12;
      res = round_mul(r5, val1 - val2) + val2;
    end
    if (res < 0) begin
      res = 0;
    end else if (res > UNIT) begin
      res = UNIT;
    end
    return val_t'(res);
  endfunction

  function automatic val_t rand_rel();
    val_t v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = VAL_ONE;
      2: v = val_t'($urandom_range(int'(VAL_ONE) + 1, int'(REL_MAX)));
      3: v = VAL_ONE - val_t'($urandom_range(1, 64));
      4: v = val_t'($urandom_range(0, 64));
      default: v = val_t'($urandom_range(0, int'(VAL_ONE)));
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_reliability.size());
      $display("testbench: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(1, 9) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      pending_reliability.push_back(predict_reliability(identical_shadow, in_rel_one,
          in_rel_two, in_rel_three, in_rel_four, in_rel_bridge));
      if (identical_shadow) begin
        identical_items++;
      end else begin
        generic_items++;
      end
    end
  end

  always @(posedge clk) begin
    val_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reliability.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("unexpected result %0d at cycle %0d", out_sys_reliability, cycle_count);
        end
      end else begin
        want = pending_reliability.pop_front();
        results_checked++;
        if (out_sys_reliability !== want) begin
          error_count++;
          if (error_count <= 10) begin
            $display("result %0d: sys_reliability expected %0d, got %0d", results_checked,
                     want, out_sys_reliability);
          end
        end
      end
    end
  end

  task automatic send_request(input val_t r1, input val_t r2, input val_t r3, input val_t r4,
                              input val_t r5);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rel_one <= r1;
    in_rel_two <= r2;
    in_rel_three <= r3;
    in_rel_four <= r4;
    in_rel_bridge <= r5;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reliability.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(input logic identical);
    cfg_we <= 1'b1;
    cfg_wdata <= identical;
    @(posedge clk);
    cfg_we <= 1'b0;
    identical_shadow = identical;
    mode_writes++;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_request(rand_rel(), rand_rel(), rand_rel(), rand_rel(), rand_rel());
  endtask

  // Runs in the mode left by reset, so the reset value of the mode is checked too.
  task automatic test_generic_corners();
    send_request('0, '0, '0, '0, '0);
    send_request(VAL_ONE, VAL_ONE, VAL_ONE, VAL_ONE, VAL_ONE);
    send_request(REL_MAX, REL_MAX, REL_MAX, REL_MAX, REL_MAX);
    send_request(val_t'(VAL_ONE + 1), val_t'(VAL_ONE + 1), val_t'(VAL_ONE + 1),
                 val_t'(VAL_ONE + 1), val_t'(VAL_ONE + 1));
    send_request(VAL_ONE, '0, VAL_ONE, '0, VAL_ONE);
    send_request('0, VAL_ONE, '0, VAL_ONE, '0);
    send_request(VAL_ONE, '0, '0, VAL_ONE, VAL_ONE);
    send_request(REL_HALF, REL_HALF, REL_HALF, REL_HALF, REL_HALF);
    send_request(val_t'(1), val_t'(1), val_t'(1), val_t'(1), val_t'(1));
    send_request(val_t'(VAL_ONE - 1), val_t'(VAL_ONE - 1), val_t'(VAL_ONE - 1),
                 val_t'(VAL_ONE - 1), val_t'(VAL_ONE - 1));
    send_request(VAL_ONE, VAL_ONE, '0, '0, REL_HALF);
    send_request(val_t'(17'h15555), val_t'(17'h0AAAA), val_t'(17'h15555), val_t'(17'h0AAAA),
                 val_t'(17'h15555));
    drain();
  endtask

  // The other four fields carry garbage that the identical mode must ignore.
  task automatic test_identical_corners();
    val_t corner[9];
    corner = '{'0, val_t'(1), REL_HALF, val_t'(VAL_ONE - 1), VAL_ONE, val_t'(VAL_ONE + 1),
               REL_MAX, val_t'(17'h15555), val_t'(17'h0AAAA)};
    write_mode(1'b1);
    foreach (corner[i]) begin
      send_request(corner[i], rand_rel(), rand_rel(), rand_rel(), rand_rel());
    end
    drain();
  endtask

  task automatic test_generic_random();
    write_mode(1'b0);
    send_random(300);
    drain();
  endtask

  task automatic test_identical_random();
    write_mode(1'b1);
    send_random(200);
    drain();
  endtask

  task automatic test_mode_switching();
    repeat (4) begin
      write_mode(~identical_shadow);
      send_random(50);
      drain();
    end
  endtask

  task automatic test_steady_stream();
    quiet = 1'b1;
    write_mode(1'($urandom_range(0, 1)));
    send_random(100);
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_generic_corners();
    test_identical_corners();
    test_generic_random();
    test_identical_random();
    test_mode_switching();
    test_steady_stream();
    repeat (10) @(posedge clk);
    $display("covered %0d generic and %0d identical-mode requests over %0d mode writes,",
             generic_items, identical_items, mode_writes);
    $display("with %0d results checked and %0d mismatches", results_checked, error_count);
    if (error_count == 0 && pending_reliability.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

/* files.f */
design/bre_pkg.sv
design/bre_fxmul.sv
design/bridge_reliability_eval.sv
design/bre_chk.sv
tb/testbench.sv
